/* rtl/ckre_pkg.sv */
// Shared types, register indexes and key-match function for the color-key run extractor.
`default_nettype none

package ckre_pkg;

  localparam logic [7:0] CH_MAX = 8'hFF;
  localparam int CFG_AW = 3;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_KEY_COLOR    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_TOLERANCE    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_IMAGE_HEIGHT = 3'd3;

  typedef struct packed {
    logic [23:0] pixel_rgb;
  } pix_req_t;

  typedef struct packed {
    logic        run_valid;
    logic [11:0] run_left;
    logic [12:0] run_right;
    logic [11:0] run_row;
    logic        frame_done;
    logic [23:0] run_count;
    logic [11:0] box_left;
    logic [11:0] box_top;
    logic [12:0] box_right;
    logic [12:0] box_bottom;
  } res_req_t;

  // True when channel value c lies in [lo, min(255, lo + tol)].
  function automatic logic chan_in_key(logic [7:0] c, logic [7:0] lo, logic [7:0] tol);
    logic [8:0] sum;
    logic [7:0] hi;
    sum = {1'b0, lo} + {1'b0, tol};
    hi  = sum[8] ? CH_MAX : sum[7:0];
    return (c >= lo) && (c <= hi);
  endfunction

endpackage

`default_nettype wire

/* rtl/ckre_if.sv */
// Channel interfaces: pixel input, result output and configuration writes.
`default_nettype none

interface ckre_pix_if;
  logic               valid;
  logic               ready;
  ckre_pkg::pix_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ckre_res_if;
  logic               valid;
  logic               ready;
  ckre_pkg::res_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ckre_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ckre_pkg::CFG_AW-1:0] addr;
  logic [23:0]                 data;
  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* rtl/color_key_run_extractor.sv */
// Color-key run extractor: opaque horizontal runs, run count and bounding box per frame.
//
//  channel | dir | payload                                   | request moved
//  --------+-----+-------------------------------------------+----------------------------
//  pix     | in  | pixel_rgb                                 | one pixel, raster order
//  res     | out | run rectangle and/or frame summary        | one per closed run/frame end
//  cfg     | in  | addr, data                                | one register write
//
// Throughput is one pixel per clock: the pixel register feeds a single short stage
// (three 8-bit range checks, a column/row compare and the box min/max) into the
// result register. Each result is registered in the result register after its pixel has passed the pixel register.
// Reset (rst, synchronous) loads the register defaults and clears frame position,
// run state, count and box. A held result stalls the pixel register only when that
// pixel produces a result of its own; pixels that produce none keep flowing.
`default_nettype none

module color_key_run_extractor #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ckre_pix_if.sink    pix,
  ckre_res_if.source  res,
  ckre_cfg_if.sink    cfg
);

  // Internal widths follow the frame size limits; port fields stay fixed.
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RHW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LW  = (CW > 12) ? CW : 12;
  localparam int TW  = (RHW > 12) ? RHW : 12;
  localparam int RRW = (CW + 1 > 13) ? CW + 1 : 13;
  localparam int BBW = (RHW + 1 > 13) ? RHW + 1 : 13;

  // Configuration registers
  logic [23:0] key_color;
  logic [23:0] tolerance;
  logic [12:0] image_width;
  logic [12:0] image_height;

  // Frame state
  logic [CW-1:0]  column;
  logic [RHW-1:0] row;
  logic           in_run;
  logic [CW-1:0]  run_start;
  logic [23:0]    runs_so_far;
  logic [LW-1:0]  bound_left;
  logic [TW-1:0]  bound_top;
  logic [RRW-1:0] bound_right;
  logic [BBW-1:0] bound_bottom;

  // Pixel register and result register
  logic               s1_valid;
  logic [23:0]        s1_pixel;
  logic               out_valid;
  ckre_pkg::res_req_t out_data;

  // Stage logic
  logic [CW:0]        width_eff;
  logic [RHW:0]       height_eff;
  logic [CW:0]        col_inc;
  logic [RHW:0]       row_inc;
  logic               end_row;
  logic               end_frame;
  logic               opaque;
  logic               closed;
  logic               has_res;
  logic               advance;
  logic [CW-1:0]      run_l;
  logic [CW:0]        run_r;
  logic [23:0]        runs_so_far_next;
  logic [LW-1:0]      bound_left_next;
  logic [TW-1:0]      bound_top_next;
  logic [RRW-1:0]     bound_right_next;
  logic [BBW-1:0]     bound_bottom_next;
  logic [CW-1:0]      column_next;
  logic [RHW-1:0]     row_next;
  logic               in_run_next;
  logic [CW-1:0]      run_start_next;
  ckre_pkg::res_req_t out_data_next;

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_color    <= 24'd0;
      tolerance    <= 24'd0;
      image_width  <= 13'd640;
      image_height <= 13'd480;
    end else if (cfg.valid) begin
      case (cfg.addr)
        ckre_pkg::REG_KEY_COLOR:    key_color    <= cfg.data;
        ckre_pkg::REG_TOLERANCE:    tolerance    <= cfg.data;
        ckre_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data[12:0];
        ckre_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data[12:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size: zero acts as one, anything above the limit acts as the limit.
  always_comb begin
    if (image_width == 13'd0) begin
      width_eff = (CW+1)'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      width_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      width_eff = (CW+1)'(image_width);
    end
    if (image_height == 13'd0) begin
      height_eff = (RHW+1)'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      height_eff = (RHW+1)'(MAX_HEIGHT);
    end else begin
      height_eff = (RHW+1)'(image_height);
    end
  end

  // ---------------------------------------------------------------- stage
  always_comb begin
    opaque = !(ckre_pkg::chan_in_key(s1_pixel[23:16], key_color[23:16], tolerance[23:16]) &&
               ckre_pkg::chan_in_key(s1_pixel[15:8],  key_color[15:8],  tolerance[15:8])  &&
               ckre_pkg::chan_in_key(s1_pixel[7:0],   key_color[7:0],   tolerance[7:0]));

    // Columns past a shrunken width end the row at once; rows past a shrunken height end the frame at that row's end.
    col_inc   = {1'b0, column} + (CW+1)'(1);
    row_inc   = {1'b0, row} + (RHW+1)'(1);
    end_row   = col_inc >= width_eff;
    end_frame = end_row && (row_inc >= height_eff);

    // An opaque pixel closes its run at row end; a transparent one closes an open run.
    closed         = opaque ? end_row : in_run;
    run_start_next = (opaque && !in_run) ? column : run_start;
    run_l          = run_start_next;
    run_r          = opaque ? col_inc : {1'b0, column};
    in_run_next    = opaque && !end_row;

    runs_so_far_next  = runs_so_far;
    bound_left_next   = bound_left;
    bound_top_next    = bound_top;
    bound_right_next  = bound_right;
    bound_bottom_next = bound_bottom;
    if (closed) begin
      if (runs_so_far != 24'hFFFFFF) begin
        runs_so_far_next = runs_so_far + 24'd1;
      end
      if (LW'(run_l) < bound_left) begin
        bound_left_next = LW'(run_l);
      end
      if (TW'(row) < bound_top) begin
        bound_top_next = TW'(row);
      end
      if (RRW'(run_r) > bound_right) begin
        bound_right_next = RRW'(run_r);
      end
      if (BBW'(row_inc) > bound_bottom) begin
        bound_bottom_next = BBW'(row_inc);
      end
    end

    if (end_row) begin
      column_next = '0;
      row_next    = end_frame ? '0 : row_inc[RHW-1:0];
    end else begin
      column_next = col_inc[CW-1:0];
      row_next    = row;
    end

    has_res = closed || end_frame;

    // Zero the fields that do not apply to this result.
    out_data_next            = '0;
    out_data_next.run_valid  = closed;
    out_data_next.frame_done = end_frame;
    if (closed) begin
      out_data_next.run_left  = 12'(run_l);
      out_data_next.run_right = 13'(run_r);
      out_data_next.run_row   = 12'(row);
    end
    if (end_frame) begin
      out_data_next.run_count = runs_so_far_next;
      if (runs_so_far_next != 24'd0) begin
        out_data_next.box_left   = 12'(bound_left_next);
        out_data_next.box_top    = 12'(bound_top_next);
        out_data_next.box_right  = 13'(bound_right_next);
        out_data_next.box_bottom = 13'(bound_bottom_next);
      end
    end
  end

  // Advance the pixel register unless its result would overwrite a held one.
  assign advance   = s1_valid && (!has_res || !out_valid || res.ready);
  assign pix.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix.ready) begin
      s1_valid <= pix.valid;
    end
    if (pix.valid && pix.ready) begin
      s1_pixel <= pix.data.pixel_rgb;
    end
  end

  // Update frame state; drop everything back to the empty frame after its last pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      column       <= '0;
      row          <= '0;
      in_run       <= 1'b0;
      run_start    <= '0;
      runs_so_far  <= 24'd0;
      bound_left   <= LW'(12'hFFF);
      bound_top    <= TW'(12'hFFF);
      bound_right  <= '0;
      bound_bottom <= '0;
    end else if (advance) begin
      column <= column_next;
      row    <= row_next;
      if (end_frame) begin
        in_run       <= 1'b0;
        run_start    <= '0;
        runs_so_far  <= 24'd0;
        bound_left   <= LW'(12'hFFF);
        bound_top    <= TW'(12'hFFF);
        bound_right  <= '0;
        bound_bottom <= '0;
      end else begin
        in_run       <= in_run_next;
        run_start    <= run_start_next;
        runs_so_far  <= runs_so_far_next;
        bound_left   <= bound_left_next;
        bound_top    <= bound_top_next;
        bound_right  <= bound_right_next;
        bound_bottom <= bound_bottom_next;
      end
    end
  end

  // Result register: load on a producing advance, release when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && has_res) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && has_res) begin
      out_data <= out_data_next;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;

  // ---------------------------------------------------------------- checks
  a_res_nonempty: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.data.run_valid || res.data.frame_done))
    else $error("result carries neither a run nor a frame end");

  a_run_order: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && closed) |-> (run_r > {1'b0, run_l}))
    else $error("closed run has right edge not past left edge");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    in_run |-> (run_start <= column))
    else $error("open run starts beyond current column");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && end_frame) |=> (column == '0 && row == '0 && !in_run && runs_so_far == 24'd0))
    else $error("frame state not cleared after last pixel");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |-> (out_valid && !res.ready))
    else $error("pixel register stalled without a held result");

endmodule

`default_nettype wire
